### design/nru_pkg.sv
// nru_pkg: shared constants, types and microcode ROM of the Newton reciprocal unit.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package nru_pkg;

   localparam int FRAC_BITS        = 16;
   localparam int MAX_NEWTON_STEPS = 15;

   localparam int A_W      = 32;
   localparam int EXP_W    = 6;
   localparam int MANT_W   = 32;
   localparam int NSTEPS_W = 4;
   localparam int STATUS_W = 2;
   localparam int TOL_W    = 5;
   localparam int LZ_W     = 5;
   localparam int PROD_W   = 64;
   localparam int P_W      = 33;
   localparam int CNT_W    = ($clog2(MAX_NEWTON_STEPS + 1) > NSTEPS_W) ?
                             $clog2(MAX_NEWTON_STEPS + 1) : NSTEPS_W;
   localparam int UPC_W    = 4;

   localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(24);
   localparam logic [TOL_W-1:0]    TOL_MAX      = TOL_W'(30);
   localparam logic [P_W-1:0]      ONE_Q30      = P_W'(1) << 30;
   localparam logic [P_W-1:0]      TWO_Q30      = P_W'(1) << 31;
   localparam logic [MANT_W-1:0]   MANT_ONE     = MANT_W'(1) << 30;
   localparam logic [A_W-1:0]      LOWER_LIMIT  = A_W'(32'hC000_0000);
   localparam logic [LZ_W-1:0]     LZ_LOWER_MAX = LZ_W'(31 - FRAC_BITS);
   localparam logic signed [EXP_W:0] E_BIAS     = (EXP_W + 1)'(32 - FRAC_BITS);
   localparam logic [CNT_W-1:0]    STEP_CAP     = CNT_W'(MAX_NEWTON_STEPS);
   localparam logic [CNT_W-1:0]    STEP_OUT_SAT = CNT_W'(15);

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;

   typedef logic [2:0] nru_op_type;
   localparam nru_op_type OP_NOP     = 3'd0;
   localparam nru_op_type OP_NBYTE   = 3'd1;
   localparam nru_op_type OP_NBIT    = 3'd2;
   localparam nru_op_type OP_SETUP   = 3'd3;
   localparam nru_op_type OP_MUL_P   = 3'd4;
   localparam nru_op_type OP_LATCH_P = 3'd5;
   localparam nru_op_type OP_MUL_M   = 3'd6;
   localparam nru_op_type OP_UPD_M   = 3'd7;

   typedef logic [2:0] nru_cond_type;
   localparam nru_cond_type C_NEXT   = 3'd0;
   localparam nru_cond_type C_ALWAYS = 3'd1;
   localparam nru_cond_type C_ZERO   = 3'd2;
   localparam nru_cond_type C_CONV   = 3'd3;
   localparam nru_cond_type C_LIMIT  = 3'd4;

   // microcode addresses
   localparam logic [UPC_W-1:0] UA_NBYTE   = 4'd0;
   localparam logic [UPC_W-1:0] UA_NBIT    = 4'd1;
   localparam logic [UPC_W-1:0] UA_SETUP   = 4'd2;
   localparam logic [UPC_W-1:0] UA_MUL_P   = 4'd3;
   localparam logic [UPC_W-1:0] UA_LATCH_P = 4'd4;
   localparam logic [UPC_W-1:0] UA_MUL_M   = 4'd5;
   localparam logic [UPC_W-1:0] UA_UPD_M   = 4'd6;
   localparam logic [UPC_W-1:0] UA_ZERO    = 4'd7;
   localparam logic [UPC_W-1:0] UA_OK      = 4'd8;
   localparam logic [UPC_W-1:0] UA_LIMIT   = 4'd9;

   typedef struct packed {
      nru_op_type          op;
      nru_cond_type        cond;
      logic [UPC_W-1:0]    target;
      logic                fin;
      logic [STATUS_W-1:0] status;
   } nru_uword_type;

   typedef struct packed {
      nru_op_type          op;
      logic                done;
      logic [STATUS_W-1:0] status;
   } nru_ctrl_type;

   typedef struct packed {
      logic zero;
      logic conv;
      logic limit;
   } nru_flags_type;

   typedef struct packed {
      logic signed [EXP_W-1:0] exponent;
      logic [MANT_W-1:0]       mantissa;
      logic [MANT_W-1:0]       product;
      logic [NSTEPS_W-1:0]     steps;
      logic [STATUS_W-1:0]     status;
   } nru_result_type;

   function automatic nru_uword_type rom_word(input logic [UPC_W-1:0] pc);
      nru_uword_type w;
      w = '0;
      case (pc)
         UA_NBYTE: begin
            w.op = OP_NBYTE; w.cond = C_ZERO; w.target = UA_ZERO;
         end
         UA_NBIT:    w.op = OP_NBIT;
         UA_SETUP:   w.op = OP_SETUP;
         UA_MUL_P:   w.op = OP_MUL_P;
         UA_LATCH_P: begin
            w.op = OP_LATCH_P; w.cond = C_CONV; w.target = UA_OK;
         end
         UA_MUL_M: begin
            w.op = OP_MUL_M; w.cond = C_LIMIT; w.target = UA_LIMIT;
         end
         UA_UPD_M: begin
            w.op = OP_UPD_M; w.cond = C_ALWAYS; w.target = UA_MUL_P;
         end
         UA_ZERO: begin
            w.fin = 1'b1; w.status = ST_ZERO;
         end
         UA_OK: begin
            w.fin = 1'b1; w.status = ST_OK;
         end
         UA_LIMIT: begin
            w.fin = 1'b1; w.status = ST_LIMIT;
         end
         default: begin
            w.fin = 1'b1; w.status = ST_OK;
         end
      endcase
      return w;
   endfunction

endpackage

### design/nru_req_if.sv
// nru_req_if: operand channel (valid/ready plus a_value).
// Depends on nru_pkg.
`timescale 1ns / 1ps

interface nru_req_if import nru_pkg::*; ();
   logic           valid;
   logic           ready;
   logic [A_W-1:0] a_value;

   modport source (output valid, output a_value, input ready);
   modport sink (input valid, input a_value, output ready);
   modport monitor (input valid, input a_value, input ready);
endinterface

### design/nru_rsp_if.sv
// nru_rsp_if: result channel (valid/ready plus reciprocal fields).
// Depends on nru_pkg.
`timescale 1ns / 1ps

interface nru_rsp_if import nru_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [EXP_W-1:0] recip_exponent;
   logic [MANT_W-1:0]       recip_mantissa;
   logic [MANT_W-1:0]       final_product;
   logic [NSTEPS_W-1:0]     newton_steps;
   logic [STATUS_W-1:0]     status;

   modport source (output valid, output recip_exponent, output recip_mantissa,
                   output final_product, output newton_steps, output status,
                   input ready);
   modport sink (input valid, input recip_exponent, input recip_mantissa,
                 input final_product, input newton_steps, input status,
                 output ready);
   modport monitor (input valid, input recip_exponent, input recip_mantissa,
                    input final_product, input newton_steps, input status,
                    input ready);
endinterface

### design/newton_reciprocal_unit_top.sv
// newton_reciprocal_unit_top: Newton-Raphson reciprocal of an unsigned Q16.16 operand.
// Depends on nru_pkg, nru_req_if, nru_rsp_if, nru_sequencer and nru_datapath.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        a_value
//   rsp_chan  out        valid/ready        recip_exponent, recip_mantissa,
//                                           final_product, newton_steps, status
//   csr_*     in         csr_we             csr_wdata = tolerance_shift
//
// One item at a time. A zero operand goes straight from the byte normalise to its result;
// any other is normalised (byte shift, bit shift, setup), then runs Newton steps on
// the one shared 32x32 multiplier (multiply, latch and check, multiply, update)
// until it converges or the step cap ends it. ready returns with rsp_chan.valid.
// req_chan.ready is high while the sequencer is idle; a result held by a stalled
// rsp_chan stalls the sequencer at its final step. Reset is synchronous and
// restores tolerance_shift to 24.
`timescale 1ns / 1ps

module newton_reciprocal_unit_top import nru_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [TOL_W-1:0] csr_wdata,
   nru_req_if.sink          req_chan,
   nru_rsp_if.source        rsp_chan
);

   logic [TOL_W-1:0] tol_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   nru_result_type   rsp_data_ff, rsp_data_in;
   nru_result_type   dp_result;
   nru_ctrl_type     ctrl;
   nru_flags_type    flags;
   logic             busy;
   logic             accept;
   logic             out_hold;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_hold = rsp_valid_ff && !rsp_chan.ready;

   nru_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .out_hold (out_hold),
      .flags    (flags),
      .ctrl     (ctrl),
      .busy     (busy)
   );

   nru_datapath u_dp (
      .clock     (clock),
      .load      (accept),
      .a_value   (req_chan.a_value),
      .tolerance (tol_ff),
      .ctrl      (ctrl),
      .flags     (flags),
      .result    (dp_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = dp_result;
         if (ctrl.status == ST_ZERO) begin
            rsp_data_in        = '0;
            rsp_data_in.status = ST_ZERO;
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            tol_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready          = !busy;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.recip_exponent = rsp_data_ff.exponent;
   assign rsp_chan.recip_mantissa = rsp_data_ff.mantissa;
   assign rsp_chan.final_product  = rsp_data_ff.product;
   assign rsp_chan.newton_steps   = rsp_data_ff.steps;
   assign rsp_chan.status         = rsp_data_ff.status;

endmodule

### design/nru_sequencer.sv
// nru_sequencer: micro-program counter, jump logic and busy flag.
// Depends on nru_pkg (control word ROM, op and condition codes).
`timescale 1ns / 1ps

module nru_sequencer import nru_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          out_hold,
   input  nru_flags_type flags,
   output nru_ctrl_type  ctrl,
   output logic          busy
);

   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] pc_ff, pc_in;
   nru_uword_type    word;
   logic             take;

   assign word = rom_word(pc_ff);

   always_comb begin
      case (word.cond)
         C_NEXT:   take = 1'b0;
         C_ALWAYS: take = 1'b1;
         C_ZERO:   take = flags.zero;
         C_CONV:   take = flags.conv;
         C_LIMIT:  take = flags.limit;
         default:  take = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = UA_NBYTE;
         end
      end else if (word.fin) begin
         if (!out_hold) begin
            busy_in = 1'b0;
         end
      end else if (take) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= UA_NBYTE;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign ctrl.op     = busy_ff ? word.op : OP_NOP;
   assign ctrl.done   = busy_ff && word.fin && !out_hold;
   assign ctrl.status = word.status;
   assign busy        = busy_ff;

endmodule

### design/nru_datapath.sv
// nru_datapath: normaliser, shared 32x32 multiplier and Newton registers.
// Depends on nru_pkg; driven by nru_sequencer control words.
`timescale 1ns / 1ps

module nru_datapath import nru_pkg::*; (
   input  logic             clock,
   input  logic             load,
   input  logic [A_W-1:0]   a_value,
   input  logic [TOL_W-1:0] tolerance,
   input  nru_ctrl_type     ctrl,
   output nru_flags_type    flags,
   output nru_result_type   result
);

   logic [A_W-1:0]          w_ff, w_in;
   logic [LZ_W-1:0]         lz_ff, lz_in;
   logic [A_W-1:0]          an_ff, an_in;
   logic signed [EXP_W-1:0] e_ff, e_in;
   logic [MANT_W-1:0]       m_ff, m_in;
   logic [MANT_W-1:0]       f_ff, f_in;
   logic [P_W-1:0]          p_ff, p_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [CNT_W-1:0]        steps_ff, steps_in;

   logic [1:0]              zb;
   logic [2:0]              zbit;
   logic                    lower;
   logic signed [EXP_W:0]   e_wide;
   logic [MANT_W-1:0]       mul_a;
   logic [P_W-1:0]          p_now, p_dist, win;
   logic [TOL_W-1:0]        tol_eff;

   // leading zero bytes, then leading zero bits of the top byte
   always_comb begin
      zb = 2'd3;
      if (w_ff[31:24] != 8'd0) begin
         zb = 2'd0;
      end else if (w_ff[23:16] != 8'd0) begin
         zb = 2'd1;
      end else if (w_ff[15:8] != 8'd0) begin
         zb = 2'd2;
      end
   end

   always_comb begin
      zbit = 3'd7;
      for (int i = 0; i < 8; i++) begin
         if (w_ff[24 + i]) begin
            zbit = 3'(7 - i);
         end
      end
   end

   assign lower  = (lz_ff <= LZ_LOWER_MAX) && (w_ff <= LOWER_LIMIT);
   assign e_wide = $signed({2'b00, lz_ff}) - E_BIAS + $signed({{EXP_W{1'b0}}, lower});

   assign mul_a  = (ctrl.op == OP_MUL_M) ? f_ff : an_ff;

   // convergence test on the product just out of the multiplier
   assign p_now   = prod_ff[62:30];
   assign p_dist  = (p_now >= ONE_Q30) ? (p_now - ONE_Q30) : (ONE_Q30 - p_now);
   assign tol_eff = (tolerance > TOL_MAX) ? TOL_MAX : tolerance;
   assign win     = P_W'(1) << (TOL_MAX - tol_eff);

   always_comb begin
      w_in     = w_ff;
      lz_in    = lz_ff;
      an_in    = an_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      f_in     = f_ff;
      p_in     = p_ff;
      prod_in  = prod_ff;
      steps_in = steps_ff;
      if (load) begin
         w_in = a_value;
      end
      case (ctrl.op)
         OP_NOP: begin
         end
         OP_NBYTE: begin
            w_in  = w_ff << {zb, 3'b000};
            lz_in = {zb, 3'b000};
         end
         OP_NBIT: begin
            w_in  = w_ff << zbit;
            lz_in = lz_ff + {2'b00, zbit};
         end
         OP_SETUP: begin
            an_in    = lower ? (w_ff >> 1) : (w_ff >> 2);
            e_in     = e_wide[EXP_W-1:0];
            m_in     = MANT_ONE;
            steps_in = '0;
         end
         OP_MUL_P, OP_MUL_M: begin
            prod_in = PROD_W'(mul_a) * PROD_W'(m_ff);
         end
         OP_LATCH_P: begin
            p_in = p_now;
            f_in = (p_now < TWO_Q30) ? MANT_W'(TWO_Q30 - p_now) : '0;
         end
         OP_UPD_M: begin
            m_in     = (prod_ff[63:62] != 2'b00) ? '1 : prod_ff[61:30];
            steps_in = steps_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      lz_ff    <= lz_in;
      an_ff    <= an_in;
      e_ff     <= e_in;
      m_ff     <= m_in;
      f_ff     <= f_in;
      p_ff     <= p_in;
      prod_ff  <= prod_in;
      steps_ff <= steps_in;
   end

   assign flags.zero  = (w_ff == '0);
   assign flags.conv  = (p_dist <= win);
   assign flags.limit = (steps_ff >= STEP_CAP);

   assign result.exponent = e_ff;
   assign result.mantissa = m_ff;
   assign result.product  = p_ff[MANT_W-1:0];
   assign result.steps    = (steps_ff > STEP_OUT_SAT) ? 4'd15 : steps_ff[NSTEPS_W-1:0];
   assign result.status   = ctrl.status;

endmodule

### design/nru_checker.sv
// nru_checker: port-level assertions for the Newton reciprocal unit, bound to the top.
// Depends on nru_pkg; the bind picks the signals off the top's channel ports.
`timescale 1ns / 1ps

module nru_checker import nru_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [EXP_W-1:0] rsp_recip_exponent,
   input logic [MANT_W-1:0]       rsp_recip_mantissa,
   input logic [MANT_W-1:0]       rsp_final_product,
   input logic [NSTEPS_W-1:0]     rsp_newton_steps,
   input logic [STATUS_W-1:0]     rsp_status
);

   localparam logic [NSTEPS_W-1:0] LIMIT_STEPS =
      (MAX_NEWTON_STEPS > 15) ? 4'd15 : NSTEPS_W'(MAX_NEWTON_STEPS);

   // a stalled result item stays valid and keeps its mantissa, product and status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_recip_mantissa) &&
         $stable(rsp_final_product) && $stable(rsp_status))
      else $error("result item changed while stalled");

   // one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ZERO |->
         rsp_recip_mantissa == '0 && rsp_final_product == '0 &&
         rsp_recip_exponent == '0 && rsp_newton_steps == '0)
      else $error("zero operand result carries data");

   a_limit_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_LIMIT |->
         rsp_newton_steps == LIMIT_STEPS)
      else $error("step limit flagged at wrong count");

endmodule

bind newton_reciprocal_unit_top nru_checker u_nru_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_recip_exponent (rsp_chan.recip_exponent),
   .rsp_recip_mantissa (rsp_chan.recip_mantissa),
   .rsp_final_product  (rsp_chan.final_product),
   .rsp_newton_steps   (rsp_chan.newton_steps),
   .rsp_status         (rsp_chan.status)
);

### tb/nru_recip_checker.sv
// nru_recip_checker: watches the operand, result and tolerance ports of the reciprocal unit,
// predicts each result and compares it field by field. Depends on nru_pkg, nru_req_if, nru_rsp_if.
`timescale 1ns / 1ps

module nru_recip_checker import nru_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [TOL_W-1:0] csr_wdata,
   nru_req_if.monitor       req_mon,
   nru_rsp_if.monitor       rsp_mon,
   output int               error_count,
   output int               pending,
   output int               checked_count,
   output int               cap_count,
   output int               zero_count
);

   typedef struct {
      logic [A_W-1:0] operand;
      nru_result_type want;
   } recip_entry_type;

   recip_entry_type  expected_recips [$];
   logic [TOL_W-1:0] tol_shadow;

   initial begin
      error_count   = 0;
      pending       = 0;
      checked_count = 0;
      cap_count     = 0;
      zero_count    = 0;
      tol_shadow    = TOL_RESET;
   end

   function automatic nru_result_type calc_reciprocal(input logic [A_W-1:0] a,
                                                      input logic [TOL_W-1:0] tol);
      nru_result_type r;
      int          scale;
      int          k;
      int          sh;
      int          eff_tol;
      int          steps;
      bit          done;
      logic [63:0] an, mant, prod, fac, nxt, win, diff, one_q, two_q;
      r = '0;
      if (a == '0) begin
         r.status = ST_ZERO;
         return r;
      end
      one_q = 64'd1 << 30;
      two_q = 64'd1 << 31;
      // coarse normalisation: bring a*2^scale into [0.5, 1.5]
      scale = 0;
      k = FRAC_BITS - 1;
      while (k >= 0 && 64'(a) < (64'd1 << k)) begin
         scale++;
         k--;
      end
      while (k < 32 && 64'(a) > (64'd3 << k)) begin
         scale--;
         k++;
      end
      sh = scale + 30 - FRAC_BITS;
      an = (sh >= 0) ? (64'(a) << sh) : (64'(a) >> (-sh));
      eff_tol = (tol > TOL_MAX) ? int'(TOL_MAX) : int'(tol);
      win = 64'd1 << (30 - eff_tol);
      mant = one_q;
      steps = 0;
      done = 1'b0;
      while (!done) begin
         prod = (an * mant) >> 30;
         diff = (prod > one_q) ? prod - one_q : one_q - prod;
         if (diff <= win) begin
            r.status = ST_OK;
            done = 1'b1;
         end else if (steps >= MAX_NEWTON_STEPS) begin
            r.status = ST_LIMIT;
            done = 1'b1;
         end else begin
            fac = (prod < two_q) ? two_q - prod : 64'd0;
            nxt = (mant * fac) >> 30;
            mant = (nxt > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : nxt;
            steps++;
         end
      end
      r.exponent = EXP_W'(scale);
      r.mantissa = mant[MANT_W-1:0];
      r.product  = prod[MANT_W-1:0];
      r.steps    = (steps > 15) ? NSTEPS_W'(15) : NSTEPS_W'(steps);
      return r;
   endfunction

   task automatic check_field(input string what, input logic [A_W-1:0] operand,
                              input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: operand %h, %s expected %h, got %h", $time, operand, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      recip_entry_type e;
      if (reset) begin
         tol_shadow = TOL_RESET;
         expected_recips.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_recips.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, got mantissa %h status %h",
                        $time, rsp_mon.recip_mantissa, rsp_mon.status);
            end else begin
               e = expected_recips.pop_front();
               checked_count++;
               check_field("exponent", e.operand, 32'(e.want.exponent),
                           32'(rsp_mon.recip_exponent));
               check_field("mantissa", e.operand, e.want.mantissa, rsp_mon.recip_mantissa);
               check_field("product", e.operand, e.want.product, rsp_mon.final_product);
               check_field("steps", e.operand, 32'(e.want.steps), 32'(rsp_mon.newton_steps));
               check_field("status", e.operand, 32'(e.want.status), 32'(rsp_mon.status));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            e.operand = req_mon.a_value;
            e.want    = calc_reciprocal(req_mon.a_value, tol_shadow);
            if (e.want.status == ST_LIMIT)
               cap_count++;
            if (e.want.status == ST_ZERO)
               zero_count++;
            expected_recips.push_back(e);
         end
         if (csr_we)
            tol_shadow = csr_wdata;
      end
      pending = expected_recips.size();
   end

endmodule

### tb/tb_newton_reciprocal_unit_top.sv
// tb_newton_reciprocal_unit_top: drives operands and tolerance settings into the reciprocal unit
// with bursty input and a stalling result side. Depends on nru_pkg, the channel interfaces,
// newton_reciprocal_unit_top and nru_recip_checker.
`timescale 1ns / 1ps

module tb_newton_reciprocal_unit_top;
   import nru_pkg::*;

   localparam int PHASES        = 8;
   localparam int ITEMS_PER_TOL = 66;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [TOL_W-1:0] csr_wdata;

   int errors, pending, checked, capped, zeros;
   int sent_count;
   int burst_left;
   int stall_mode, mode_left, hold_left;

   nru_req_if req_bus ();
   nru_rsp_if rsp_bus ();

   newton_reciprocal_unit_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   nru_recip_checker recip_chk (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .error_count   (errors),
      .pending       (pending),
      .checked_count (checked),
      .cap_count     (capped),
      .zero_count    (zeros)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side stalls: always ready, coin flips, long holds, mostly ready
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 300);
      end
      mode_left--;
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2: begin
            if (hold_left == 0) begin
               rsp_bus.ready <= !rsp_bus.ready;
               hold_left = $urandom_range(1, 40);
            end else begin
               hold_left--;
            end
         end
         default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   function automatic logic [A_W-1:0] rand_operand();
      int             k;
      logic [A_W-1:0] v;
      case ($urandom_range(0, 5))
         0: return A_W'($urandom());
         1: return A_W'($urandom()) >> $urandom_range(0, 31);
         2: begin
            k = $urandom_range(0, 31);
            v = A_W'(1) << k;
            return v + A_W'($urandom_range(0, 2)) - A_W'(1);
         end
         3: begin
            k = $urandom_range(0, 30);
            v = A_W'(3) << k;
            return v + A_W'($urandom_range(0, 2)) - A_W'(1);
         end
         4: return ($urandom_range(0, 3) == 0) ? '0 : A_W'($urandom_range(1, 255));
         default: return A_W'(32'h0001_0000) + A_W'($urandom_range(0, 4095)) - A_W'(2048);
      endcase
   endfunction

   task automatic send_operand(input logic [A_W-1:0] operand);
      int gap;
      req_bus.valid   <= 1'b1;
      req_bus.a_value <= operand;
      do @(posedge clock); while (!req_bus.ready);
      sent_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
         gap = $urandom_range(1, 40);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [A_W-1:0]   corner_ops [$];
      logic [TOL_W-1:0] tol_plan [PHASES];
      int               waited;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.a_value = '0;
      rsp_bus.ready   = 1'b0;
      sent_count      = 0;
      burst_left      = 0;
      stall_mode      = 0;
      mode_left       = 0;
      hold_left       = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero, ends of the range, and the 0.5 / 1.0 / 1.5 boundaries at several scales
      corner_ops = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                     32'h0000_7FFF, 32'h0000_8000, 32'h0000_8001, 32'h0000_FFFF,
                     32'h0001_0000, 32'h0001_7FFF, 32'h0001_8000, 32'h0001_8001,
                     32'h0002_0000, 32'h0003_0000, 32'h0003_0001, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000, 32'hC000_0000,
                     32'hC000_0001, 32'hFFFF_FFFF};
      foreach (corner_ops[i])
         send_operand(corner_ops[i]);
      req_bus.valid <= 1'b0;

      tol_plan = '{5'd0, 5'd31, 5'd1, 5'd30, 5'd28, 5'd12, TOL_RESET,
                   5'($urandom_range(2, 27))};
      foreach (tol_plan[p]) begin
         write_tolerance(tol_plan[p]);
         repeat (ITEMS_PER_TOL)
            send_operand(rand_operand());
         req_bus.valid <= 1'b0;
      end

      waited = 0;
      @(negedge clock);
      while (pending != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);

      $display("%0d operands over %0d tolerance settings, %0d results checked", sent_count,
               PHASES + 1, checked);
      $display("%0d zero operands, %0d runs stopped at the step cap", zeros, capped);
      if (errors == 0 && pending == 0) begin
         $display("tb_newton_reciprocal_unit_top: done, clean");
      end else begin
         $display("tb_newton_reciprocal_unit_top: done, errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_newton_reciprocal_unit_top: done, errors");
      $finish;
   end

endmodule

### newton_reciprocal_unit_top.f
design/nru_pkg.sv
design/nru_req_if.sv
design/nru_rsp_if.sv
design/nru_sequencer.sv
design/nru_datapath.sv
design/newton_reciprocal_unit_top.sv
design/nru_checker.sv
tb/nru_recip_checker.sv
tb/tb_newton_reciprocal_unit_top.sv
